// ===== rtl/core/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared constants and types of the 3x3 RGB convolution pipeline.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = COL_W + 1;
    localparam int HGT_W     = 16;
    localparam int PIX_W     = 24;
    localparam int TAP_W     = 16;
    localparam int ROW_W     = 3 * TAP_W;
    localparam int PROD_W    = 24;
    localparam int PART_W    = 26;
    localparam int SUM_W     = 28;

    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TOP    = 3'd2;
    localparam logic [2:0] REG_MID    = 3'd3;
    localparam logic [2:0] REG_BOT    = 3'd4;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } t_geom;

    // window after a pixel entered, with what it emits
    typedef struct packed {
        t_win win;
        logic em_inner;
        logic em_edge;
        logic done;
    } t_wbeat;

    // one result: selected 3x3 taps and its flags
    typedef struct packed {
        t_win win;
        logic done;
        logic last;
    } t_rbeat;

endpackage

// ===== rtl/core/rcc_front.sv =====
// ----------------------------------------------------------------------------
// rcc_front
// Raster counters, two line stores and the 3x3 tap window.
// ----------------------------------------------------------------------------
module rcc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcc_pkg::t_geom  i_geom,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_mode,
    input  rcc_pkg::t_pix   i_pix,
    output logic            o_valid,
    input  logic            i_ready,
    output rcc_pkg::t_wbeat o_beat
);

    rcc_pkg::t_pix mem_a [rcc_pkg::MAX_WIDTH];
    rcc_pkg::t_pix mem_b [rcc_pkg::MAX_WIDTH];

    logic [rcc_pkg::COL_W-1:0] r_col;
    logic [rcc_pkg::HGT_W-1:0] r_row;
    logic [rcc_pkg::WID_W-1:0] w_eff;
    logic [rcc_pkg::HGT_W-1:0] h_eff;
    logic flush, drop, last_col, take;

    logic                      r_v1;
    rcc_pkg::t_pix             r_pix;
    logic [rcc_pkg::COL_W-1:0] r_c;
    logic r_flush, r_row0, r_em0, r_em1, r_c0, r_byp;
    rcc_pkg::t_pix r_rda, r_rdb, r_wa, r_wb;
    rcc_pkg::t_win r_win;

    rcc_pkg::t_pix rd_a, rd_b, wa, wb;
    rcc_pkg::t_pix v [3];
    rcc_pkg::t_win n_win;
    logic emit, s1_fire;

    always_comb begin
        if (i_geom.width == '0) begin
            w_eff = rcc_pkg::WID_W'(1);
        end else if (i_geom.width > rcc_pkg::WID_W'(rcc_pkg::MAX_WIDTH)) begin
            w_eff = rcc_pkg::WID_W'(rcc_pkg::MAX_WIDTH);
        end else begin
            w_eff = i_geom.width;
        end
        h_eff    = (i_geom.height == '0) ? rcc_pkg::HGT_W'(1) : i_geom.height;
        flush    = r_row >= h_eff;
        drop     = !flush && (i_mode == rcc_pkg::MODE_FLUSH);
        last_col = ({1'b0, r_col} + rcc_pkg::WID_W'(1)) >= w_eff;
    end

    assign emit    = r_em0 || r_em1;
    assign s1_fire = r_v1 && (!emit || i_ready);
    assign o_ready = !r_v1 || s1_fire;
    assign take    = i_valid && o_ready && !drop;

    // raster position and stage-1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (take) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= flush ? '0 : r_row + rcc_pkg::HGT_W'(1);
                end else begin
                    r_col <= r_col + rcc_pkg::COL_W'(1);
                end
            end
            if (take) begin
                r_v1 <= 1'b1;
            end else if (s1_fire) begin
                r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pix   <= flush ? '0 : i_pix;
            r_c     <= r_col;
            r_flush <= flush;
            r_row0  <= (r_row == '0);
            r_em0   <= (r_row != '0) && (r_col != '0);
            r_em1   <= (r_row != '0) && last_col;
            r_c0    <= (r_col == '0);
            r_rda   <= mem_a[r_col];
            r_rdb   <= mem_b[r_col];
            // the stage-1 beat writes this column at the same edge
            r_byp   <= s1_fire && !r_flush && (r_c == r_col);
        end
        if (s1_fire && !r_flush) begin
            mem_a[r_c] <= wa;
            mem_b[r_c] <= wb;
            r_wa       <= wa;
            r_wb       <= wb;
        end
        if (s1_fire) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        rd_a = r_byp ? r_wa : r_rda;
        rd_b = r_byp ? r_wb : r_rdb;
        if (r_flush) begin
            v[0] = rd_a;
            v[1] = rd_b;
            v[2] = rd_b;
            wa   = rd_b;
            wb   = rd_b;
        end else if (r_row0) begin
            v[0] = r_pix;
            v[1] = r_pix;
            v[2] = r_pix;
            wa   = r_pix;
            wb   = r_pix;
        end else begin
            v[0] = rd_a;
            v[1] = rd_b;
            v[2] = r_pix;
            wa   = rd_b;
            wb   = r_pix;
        end
        for (int j = 0; j < 3; j++) begin
            if (r_c0) begin
                n_win[j*3]   = v[j];
                n_win[j*3+1] = v[j];
            end else begin
                n_win[j*3]   = r_win[j*3+1];
                n_win[j*3+1] = r_win[j*3+2];
            end
            n_win[j*3+2] = v[j];
        end
    end

    assign o_valid         = r_v1 && emit;
    assign o_beat.win      = n_win;
    assign o_beat.em_inner = r_em0;
    assign o_beat.em_edge  = r_em1;
    assign o_beat.done     = r_flush;

endmodule

// ===== rtl/core/rcc_split.sv =====
// ----------------------------------------------------------------------------
// rcc_split
// Turns one window beat into one or two result beats with their tap columns.
// ----------------------------------------------------------------------------
module rcc_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rcc_pkg::t_wbeat i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output rcc_pkg::t_rbeat o_beat
);

    logic            r_v;
    logic            r_ph;
    rcc_pkg::t_wbeat r_beat;
    logic first, last_beat, out_fire;

    assign first     = r_beat.em_inner && !r_ph;
    assign last_beat = !(r_beat.em_inner && r_beat.em_edge && !r_ph);
    assign out_fire  = r_v && i_ready;
    assign o_ready   = !r_v || (i_ready && last_beat);
    assign o_valid   = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_ph <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_v  <= 1'b1;
            r_ph <= 1'b0;
        end else if (out_fire) begin
            if (last_beat) begin
                r_v <= 1'b0;
            end else begin
                r_ph <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

    // inner pixel uses left/centre/right, the edge pixel replicates the right column
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (first) begin
                o_beat.win[j*3]   = r_beat.win[j*3];
                o_beat.win[j*3+1] = r_beat.win[j*3+1];
            end else begin
                o_beat.win[j*3]   = r_beat.win[j*3+1];
                o_beat.win[j*3+1] = r_beat.win[j*3+2];
            end
            o_beat.win[j*3+2] = r_beat.win[j*3+2];
        end
        o_beat.done = first ? 1'b0 : r_beat.done;
        o_beat.last = last_beat;
    end

endmodule

// ===== rtl/core/rcc_mac.sv =====
// ----------------------------------------------------------------------------
// rcc_mac
// Multiply, sum and clamp stages for the three color channels.
// ----------------------------------------------------------------------------
module rcc_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [2:0][rcc_pkg::ROW_W-1:0]       i_coef,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  rcc_pkg::t_rbeat                      i_beat,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0][7:0]                      o_pix,
    output logic                                 o_done,
    output logic                                 o_last
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic r_done1, r_last1, r_done2, r_last2;

    logic signed [rcc_pkg::PROD_W-1:0] r_prod [3][9];
    logic signed [rcc_pkg::PART_W-1:0] r_part [3][3];
    logic signed [rcc_pkg::SUM_W-1:0]  sum    [3];

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // stage 1: 27 tap products
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_prod[ch][j*3+k] <= rcc_pkg::PROD_W'(
                            $signed({1'b0, i_beat.win[j*3+k][ch*8 +: 8]}) *
                            $signed(i_coef[j][k*rcc_pkg::TAP_W +: rcc_pkg::TAP_W]));
                    end
                end
            end
            r_done1 <= i_beat.done;
            r_last1 <= i_beat.last;
        end
    end

    // stage 2: row partial sums
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int j = 0; j < 3; j++) begin
                    r_part[ch][j] <= rcc_pkg::PART_W'(r_prod[ch][j*3])
                                   + rcc_pkg::PART_W'(r_prod[ch][j*3+1])
                                   + rcc_pkg::PART_W'(r_prod[ch][j*3+2]);
                end
            end
            r_done2 <= r_done1;
            r_last2 <= r_last1;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = rcc_pkg::SUM_W'(r_part[ch][0]) + rcc_pkg::SUM_W'(r_part[ch][1])
                    + rcc_pkg::SUM_W'(r_part[ch][2]);
        end
    end

    // stage 3: total, drop the fraction, saturate to 0..255
    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (sum[ch][rcc_pkg::SUM_W-1]) begin
                    o_pix[ch] <= 8'd0;
                end else if (|sum[ch][rcc_pkg::SUM_W-2:20]) begin
                    o_pix[ch] <= 8'd255;
                end else begin
                    o_pix[ch] <= sum[ch][19:12];
                end
            end
            o_done <= r_done2;
            o_last <= r_last2;
        end
    end

endmodule

// ===== rtl/core/rgb_conv3x3_replicate_clamp.sv =====
// ----------------------------------------------------------------------------
// rgb_conv3x3_replicate_clamp
// Streaming 3x3 convolution of RGB pixels with edge replication and clamp.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per clock while o_ready is high.
// Output pixel (c-1, r-1) comes from the window that pixel (c, r) completes;
// the last column of a row also emits the right-edge pixel, so that beat
// yields two results and the split stage takes no new input until both
// have left. After frame_height rows, send one row of frame_width flush beats
// to drain the last row. Line stores are two 1024 x 24 single-port-write
// memories read at the entering column; an accepted input beat passes five
// register stages to its first result (line store read, window into split,
// multiply, row sums, total and clamp into the output register). Coefficient
// and geometry registers sit on a 64-bit APB port at byte address 8*index.
module rgb_conv3x3_replicate_clamp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_pix_red,
    input  logic [7:0]  i_pix_green,
    input  logic [7:0]  i_pix_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_frame_done,
    output logic        o_run_last
);

    logic [rcc_pkg::WID_W-1:0] r_width;
    logic [rcc_pkg::HGT_W-1:0] r_height;
    logic [2:0][rcc_pkg::ROW_W-1:0] r_coef;
    logic [2:0] reg_idx;

    rcc_pkg::t_geom  geom;
    rcc_pkg::t_wbeat wbeat;
    rcc_pkg::t_rbeat rbeat;
    logic w_valid, w_ready, r_valid, r_ready;
    logic [2:0][7:0] out_pix;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rcc_pkg::WID_W'(rcc_pkg::MAX_WIDTH);
            r_height <= rcc_pkg::HGT_W'(1);
            r_coef   <= {48'd0, 48'h0000_1000_0000, 48'd0};
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                rcc_pkg::REG_WIDTH:  r_width   <= pwdata[rcc_pkg::WID_W-1:0];
                rcc_pkg::REG_HEIGHT: r_height  <= pwdata[rcc_pkg::HGT_W-1:0];
                rcc_pkg::REG_TOP:    r_coef[0] <= pwdata[rcc_pkg::ROW_W-1:0];
                rcc_pkg::REG_MID:    r_coef[1] <= pwdata[rcc_pkg::ROW_W-1:0];
                rcc_pkg::REG_BOT:    r_coef[2] <= pwdata[rcc_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rcc_pkg::REG_WIDTH:  prdata = 64'(r_width);
            rcc_pkg::REG_HEIGHT: prdata = 64'(r_height);
            rcc_pkg::REG_TOP:    prdata = 64'(r_coef[0]);
            rcc_pkg::REG_MID:    prdata = 64'(r_coef[1]);
            rcc_pkg::REG_BOT:    prdata = 64'(r_coef[2]);
            default:             prdata = '0;
        endcase
    end

    assign geom.width  = r_width;
    assign geom.height = r_height;

    rcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_pix   ({i_pix_blue, i_pix_green, i_pix_red}),
        .o_valid (w_valid),
        .i_ready (w_ready),
        .o_beat  (wbeat)
    );

    rcc_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_ready (w_ready),
        .i_beat  (wbeat),
        .o_valid (r_valid),
        .i_ready (r_ready),
        .o_beat  (rbeat)
    );

    rcc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_valid (r_valid),
        .o_ready (r_ready),
        .i_beat  (rbeat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (out_pix),
        .o_done  (o_frame_done),
        .o_last  (o_run_last)
    );

    assign o_out_red   = out_pix[0];
    assign o_out_green = out_pix[1];
    assign o_out_blue  = out_pix[2];

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_run_last)
        else $error("frame_done on a beat that is not the last of its input");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_split_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && !w_ready && r_ready |=> w_valid)
        else $error("window beat lost while split stage busy");

endmodule
